// ----- sv/pobb_pkg.sv -----
// Shared types, constants and tables for the PCA oriented bounding box.
package pobb_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 12;
	localparam int ADDR_BITS  = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = ADDR_BITS + 1;
	localparam int SUM_BITS   = COORD_BITS + CNT_BITS - 1;
	localparam int SQ_BITS    = 2 * COORD_BITS + CNT_BITS - 1;
	localparam int CORDIC_STEPS = 22;
	localparam int STEP_BITS  = 5;
	localparam int DIV_STEPS  = SUM_BITS + 8;
	localparam int DIV_BITS   = $clog2(DIV_STEPS + 1);

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	typedef struct packed {
		logic clear;
		logic accum;
		logic init;
		logic step;
		logic ang;
		logic rot_init;
		logic rot_step;
		logic rd;
		logic pt;
		logic ext_first;
		logic ext;
	} cmd_t;

	typedef struct packed {
		logic             full;
		logic [CNT_BITS-1:0] count;
	} stat_t;

	function automatic logic [20:0] atan_unit(input logic [STEP_BITS-1:0] i);
		case (i)
			5'd0: atan_unit = 21'd1048576;
			5'd1: atan_unit = 21'd619011;
			5'd2: atan_unit = 21'd327068;
			5'd3: atan_unit = 21'd166025;
			5'd4: atan_unit = 21'd83335;
			5'd5: atan_unit = 21'd41708;
			5'd6: atan_unit = 21'd20859;
			5'd7: atan_unit = 21'd10430;
			5'd8: atan_unit = 21'd5215;
			5'd9: atan_unit = 21'd2608;
			5'd10: atan_unit = 21'd1304;
			5'd11: atan_unit = 21'd652;
			5'd12: atan_unit = 21'd326;
			5'd13: atan_unit = 21'd163;
			5'd14: atan_unit = 21'd81;
			5'd15: atan_unit = 21'd41;
			5'd16: atan_unit = 21'd20;
			5'd17: atan_unit = 21'd10;
			5'd18: atan_unit = 21'd5;
			5'd19: atan_unit = 21'd3;
			5'd20: atan_unit = 21'd1;
			5'd21: atan_unit = 21'd1;
			default: atan_unit = 21'd0;
		endcase
	endfunction

endpackage

// ----- sv/pobb_dp.sv -----
// Datapath of the PCA oriented bounding box: store, sums, dividers, CORDIC, extremes.
module pobb_dp (
	input  logic clk,
	input  logic arst_n,
	input  pobb_pkg::cmd_t cmd,
	input  logic [pobb_pkg::ADDR_BITS-1:0] rd_addr,
	input  logic [pobb_pkg::STEP_BITS-1:0] step_idx,
	input  logic [pobb_pkg::DIV_BITS-1:0] div_idx,
	input  logic [pobb_pkg::COORD_BITS-1:0] point_x,
	input  logic [pobb_pkg::COORD_BITS-1:0] point_y,
	output pobb_pkg::stat_t stat,
	output logic [19:0] center_x,
	output logic [19:0] center_y,
	output logic signed [15:0] axis_angle,
	output logic [13:0] short_side,
	output logic [13:0] long_side
);
	localparam int CB = pobb_pkg::COORD_BITS;
	localparam int CN = pobb_pkg::CNT_BITS;
	localparam int SB = pobb_pkg::SUM_BITS;
	localparam int QB = pobb_pkg::SQ_BITS;

	logic [2*CB-1:0] mem [pobb_pkg::MAX_POINTS];
	logic [2*CB-1:0] rd_data_q;
	logic [CN-1:0] count_q;
	logic [SB-1:0] sx_q, sy_q;
	logic [QB-1:0] sxx_q, syy_q, sxy_q;
	logic [CB-1:0] mx_q, my_q;
	logic [2*CB-1:0] pxx_q, pyy_q, pxy_q;
	logic acc_q;
	logic [CN-1:0] n;
	logic signed [63:0] cxx, cyy, cxy;
	logic aneg_q, bneg_q;
	logic [63:0] ay0, bx0;
	logic signed [32:0] vx_q, vy_q;
	logic signed [23:0] vz_q;
	logic vzero_q;
	logic signed [31:0] rx_q, ry_q;
	logic signed [23:0] rz_q;
	logic signed [15:0] angle_q;
	logic [SB+8:0] rem_x_q, rem_y_q;
	logic [SB+8:0] num_x_q, num_y_q;
	logic [SB+8:0] quo_x_q, quo_y_q;
	logic signed [31:0] c_q, s_q;
	logic signed [CB+9:0] dx_s1, dy_s1;
	logic signed [63:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [63:0] rxs, rys;
	logic signed [25:0] rxt, ryt;
	logic signed [25:0] minx_q, maxx_q, miny_q, maxy_q;
	logic [19:0] cx_sat, cy_sat;
	logic [26:0] w, h;
	logic [13:0] ws, hs;
	logic [5:0] sh;
	integer k;

	assign stat.full  = (count_q == CN'(pobb_pkg::MAX_POINTS));
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (cmd.accum && !stat.full)
			mem[count_q[pobb_pkg::ADDR_BITS-1:0]] <= {point_x, point_y};
		if (cmd.rd)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		mx_q <= point_x;
		my_q <= point_y;
		pxx_q <= point_x * point_x;
		pyy_q <= point_y * point_y;
		pxy_q <= point_x * point_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; acc_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0; acc_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
		end else begin
			acc_q <= cmd.accum && !stat.full;
			if (cmd.accum && !stat.full)
				count_q <= count_q + 1'b1;
			if (acc_q) begin
				sx_q <= sx_q + SB'(mx_q);
				sy_q <= sy_q + SB'(my_q);
				sxx_q <= sxx_q + QB'(pxx_q);
				syy_q <= syy_q + QB'(pyy_q);
				sxy_q <= sxy_q + QB'(pxy_q);
			end
		end
	end

	assign n = (count_q == '0) ? CN'(1) : count_q;
	always_comb begin
		cxx = $signed(64'(n) * 64'(sxx_q)) - $signed(64'(sx_q) * 64'(sx_q));
		cyy = $signed(64'(n) * 64'(syy_q)) - $signed(64'(sy_q) * 64'(sy_q));
		cxy = $signed(64'(n) * 64'(sxy_q)) - $signed(64'(sx_q) * 64'(sy_q));
		ay0 = (cxy < 0) ? 64'(-cxy) : 64'(cxy);
		ay0 = ay0 << 1;
		bx0 = (cxx < cyy) ? 64'(cyy - cxx) : 64'(cxx - cyy);
		sh = '0;
		for (k = 0; k < 34; k++)
			if (((ay0 | bx0) >> k) >= 64'd1073741824)
				sh = 6'(k + 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			aneg_q <= (cxy < 0);
			bneg_q <= (cxx < cyy);
			vx_q <= $signed({1'b0, 32'(bx0 >> sh)});
			vy_q <= $signed({1'b0, 32'(ay0 >> sh)});
			vzero_q <= ((ay0 >> sh) == 64'd0);
			vz_q <= '0;
			num_x_q <= (SB+9)'({sx_q, 8'd0}) + (SB+9)'(n >> 1);
			num_y_q <= (SB+9)'({sy_q, 8'd0}) + (SB+9)'(n >> 1);
			rem_x_q <= '0; rem_y_q <= '0; quo_x_q <= '0; quo_y_q <= '0;
		end else if (cmd.step) begin
			if (!vzero_q) begin
				if (vy_q >= 0) begin
					vx_q <= vx_q + (vy_q >>> step_idx);
					vy_q <= vy_q - (vx_q >>> step_idx);
					vz_q <= vz_q + 24'(pobb_pkg::atan_unit(step_idx));
				end else begin
					vx_q <= vx_q - (vy_q >>> step_idx);
					vy_q <= vy_q + (vx_q >>> step_idx);
					vz_q <= vz_q - 24'(pobb_pkg::atan_unit(step_idx));
				end
			end
		end
		if (cmd.step && div_idx != '0) begin
			logic [SB+9:0] tx, ty;
			tx = {rem_x_q, num_x_q[div_idx - 1'b1]};
			ty = {rem_y_q, num_y_q[div_idx - 1'b1]};
			if (tx >= (SB+10)'(n)) begin
				rem_x_q <= (SB+9)'(tx - (SB+10)'(n));
				quo_x_q[div_idx - 1'b1] <= 1'b1;
			end else
				rem_x_q <= (SB+9)'(tx);
			if (ty >= (SB+10)'(n)) begin
				rem_y_q <= (SB+9)'(ty - (SB+10)'(n));
				quo_y_q[div_idx - 1'b1] <= 1'b1;
			end else
				rem_y_q <= (SB+9)'(ty);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ang) begin
			logic signed [23:0] z;
			logic signed [23:0] r;
			z = vzero_q ? 24'sd0 : vz_q;
			if (z < 0) z = '0;
			if (z > 24'sd2097152) z = 24'sd2097152;
			if (bneg_q) z = 24'sd4194304 - z;
			if (aneg_q) z = -z;
			r = (z + 24'sd128) >>> 8;
			if (r <= -24'sd16384) r = r + 24'sd32768;
			angle_q <= 16'(r);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rot_init) begin
			rx_q <= pobb_pkg::CORDIC_GAIN;
			ry_q <= '0;
			rz_q <= 24'(angle_q) <<< 7;
		end else if (cmd.rot_step) begin
			if (rz_q >= 0) begin
				rx_q <= rx_q - (ry_q >>> step_idx);
				ry_q <= ry_q + (rx_q >>> step_idx);
				rz_q <= rz_q - 24'(pobb_pkg::atan_unit(step_idx));
			end else begin
				rx_q <= rx_q + (ry_q >>> step_idx);
				ry_q <= ry_q - (rx_q >>> step_idx);
				rz_q <= rz_q + 24'(pobb_pkg::atan_unit(step_idx));
			end
		end
	end

	always_comb begin
		if (angle_q == 16'sd0) begin
			c_q = 32'sd1073741824; s_q = '0;
		end else if (angle_q == 16'sd16384) begin
			c_q = '0; s_q = 32'sd1073741824;
		end else begin
			c_q = rx_q; s_q = ry_q;
		end
	end

	assign cx_sat = (quo_x_q > (SB+9)'(20'hFFFFF)) ? 20'hFFFFF : 20'(quo_x_q);
	assign cy_sat = (quo_y_q > (SB+9)'(20'hFFFFF)) ? 20'hFFFFF : 20'(quo_y_q);

	always_ff @(posedge clk) begin
		if (cmd.pt) begin
			dx_s1 <= $signed({2'b0, rd_data_q[2*CB-1:CB], 8'd0}) - $signed({2'b0, cx_sat});
			dy_s1 <= $signed({2'b0, rd_data_q[CB-1:0], 8'd0}) - $signed({2'b0, cy_sat});
		end
		p1_s2 <= 64'(dx_s1) * 64'(c_q);
		p2_s2 <= 64'(dy_s1) * 64'(s_q);
		p3_s2 <= 64'(dy_s1) * 64'(c_q);
		p4_s2 <= 64'(dx_s1) * 64'(s_q);
	end

	always_comb begin
		rxs = p1_s2 + p2_s2 + ($signed({44'd0, cx_sat}) <<< 30);
		rys = p3_s2 - p4_s2 + ($signed({44'd0, cy_sat}) <<< 30);
		rxt = (rxs >= 0) ? 26'(rxs >>> 38) : -26'((-rxs) >>> 38);
		ryt = (rys >= 0) ? 26'(rys >>> 38) : -26'((-rys) >>> 38);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minx_q <= '0; maxx_q <= '0; miny_q <= '0; maxy_q <= '0;
		end else if (cmd.ext_first) begin
			minx_q <= rxt; maxx_q <= rxt; miny_q <= ryt; maxy_q <= ryt;
		end else if (cmd.ext) begin
			if (rxt < minx_q) minx_q <= rxt;
			if (rxt > maxx_q) maxx_q <= rxt;
			if (ryt < miny_q) miny_q <= ryt;
			if (ryt > maxy_q) maxy_q <= ryt;
		end
	end

	assign w  = 27'(maxx_q - minx_q + 26'sd1);
	assign h  = 27'(maxy_q - miny_q + 26'sd1);
	assign ws = (w > 27'd16383) ? 14'd16383 : 14'(w);
	assign hs = (h > 27'd16383) ? 14'd16383 : 14'(h);

	assign center_x   = cx_sat;
	assign center_y   = cy_sat;
	assign axis_angle = angle_q;
	assign short_side = (ws < hs) ? ws : hs;
	assign long_side  = (ws < hs) ? hs : ws;
endmodule

// ----- sv/pobb_ctrl.sv -----
// Controller of the PCA oriented bounding box: load, solve, rotate and report sequence.
module pobb_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic last,
	input  logic out_fire,
	input  pobb_pkg::stat_t stat,
	output pobb_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_valid,
	output logic [pobb_pkg::ADDR_BITS-1:0] rd_addr,
	output logic [pobb_pkg::STEP_BITS-1:0] step_idx,
	output logic [pobb_pkg::DIV_BITS-1:0] div_idx
);
	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_WAIT  = 4'd1;
	localparam logic [3:0] S_INIT  = 4'd2;
	localparam logic [3:0] S_VEC   = 4'd3;
	localparam logic [3:0] S_ANG   = 4'd4;
	localparam logic [3:0] S_ROT   = 4'd5;
	localparam logic [3:0] S_PASS  = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_RINIT = 4'd8;

	localparam int LAT = 3;

	logic [3:0] state_q;
	logic [pobb_pkg::CNT_BITS-1:0] idx_q;
	logic [5:0] cnt_q;
	logic [pobb_pkg::CNT_BITS+2:0] pass_q;
	logic [pobb_pkg::CNT_BITS+2:0] pass_end;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign rd_addr   = idx_q[pobb_pkg::ADDR_BITS-1:0];
	assign step_idx  = cnt_q[pobb_pkg::STEP_BITS-1:0];
	assign div_idx   = pobb_pkg::DIV_BITS'(pobb_pkg::DIV_STEPS) - pobb_pkg::DIV_BITS'(cnt_q);
	assign pass_end  = (pobb_pkg::CNT_BITS+3)'(stat.count) + (pobb_pkg::CNT_BITS+3)'(LAT);

	always_comb begin
		cmd = '0;
		cmd.accum = in_fire;
		cmd.init  = (state_q == S_INIT);
		cmd.step  = (state_q == S_VEC);
		cmd.ang   = (state_q == S_ANG);
		cmd.rot_init = (state_q == S_RINIT);
		cmd.rot_step = (state_q == S_ROT);
		cmd.rd    = (state_q == S_PASS);
		cmd.pt    = (state_q == S_PASS) && pass_q >= 1;
		cmd.ext_first = (state_q == S_PASS) && pass_q == LAT;
		cmd.ext   = (state_q == S_PASS) && pass_q > LAT;
		cmd.clear = out_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			idx_q <= '0;
			cnt_q <= '0;
			pass_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: if (in_fire && last) state_q <= S_WAIT;
				S_WAIT: state_q <= S_INIT;
				S_INIT: begin
					cnt_q <= '0;
					state_q <= S_VEC;
				end
				S_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(pobb_pkg::DIV_STEPS)) begin
						cnt_q <= '0;
						state_q <= S_ANG;
					end
				end
				S_ANG: state_q <= S_RINIT;
				S_RINIT: state_q <= S_ROT;
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(pobb_pkg::CORDIC_STEPS - 1)) begin
						idx_q <= '0;
						pass_q <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					pass_q <= pass_q + 1'b1;
					if (idx_q != stat.count) idx_q <= idx_q + 1'b1;
					if (pass_q + 1'b1 == pass_end) state_q <= S_OUT;
				end
				S_OUT: if (out_fire) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("load and report overlap");
	a_out_follows_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_PASS) else $error("report without pass");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> stat.count == '0) else $error("contour not cleared");
`endif
endmodule

// ----- sv/pca_oriented_bounding_box.sv -----
// Top level of the PCA oriented bounding box over one contour of points.
// Points load at one per cycle while in_stall is low; points beyond 1024 are dropped. The last
// point starts a solve: a wait for the sums to settle, a setup step, a phase in which the
// 30-step mean divider runs beside the vectoring CORDIC, an angle step, a rotation setup step
// and the 22-step rotation CORDIC. A rotation pass over the point store through its single
// read port follows, and the one result per contour is then held until taken; in_stall stays
// high from the last point until that result is taken.
module pca_oriented_bounding_box (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [11:0] point_x,
	input  logic [11:0] point_y,
	input  logic last_point,
	output logic out_valid,
	input  logic out_stall,
	output logic [19:0] center_x,
	output logic [19:0] center_y,
	output logic signed [15:0] axis_angle,
	output logic [13:0] short_side,
	output logic [13:0] long_side
);
	pobb_pkg::cmd_t  cmd;
	pobb_pkg::stat_t stat;
	logic in_ready;
	logic in_fire, out_fire;
	logic [pobb_pkg::ADDR_BITS-1:0] rd_addr;
	logic [pobb_pkg::STEP_BITS-1:0] step_idx;
	logic [pobb_pkg::DIV_BITS-1:0] div_idx;

	assign in_stall = !in_ready;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && !out_stall;

	pobb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .last(last_point),
		.out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(in_ready),
		.out_valid(out_valid), .rd_addr(rd_addr), .step_idx(step_idx), .div_idx(div_idx)
	);

	pobb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd_addr(rd_addr), .step_idx(step_idx),
		.div_idx(div_idx), .point_x(point_x), .point_y(point_y), .stat(stat),
		.center_x(center_x), .center_y(center_y), .axis_angle(axis_angle),
		.short_side(short_side), .long_side(long_side)
	);
endmodule

// ----- sim/pca_oriented_bounding_box_test.sv -----
// Self-checking testbench for the PCA oriented bounding box: contours in, boxes checked.
module pca_oriented_bounding_box_test;

	localparam int  ITEM_TARGET = 1900;
	localparam longint RUN_LIMIT = 2000000;

	typedef struct {
		logic [19:0] cx;
		logic [19:0] cy;
		logic signed [15:0] angle;
		logic [13:0] short_len;
		logic [13:0] long_len;
	} box_t;

	// Predicts the box of each contour and matches it against the block's output.
	class box_scoreboard;
		logic [pobb_pkg::COORD_BITS-1:0] px[pobb_pkg::MAX_POINTS];
		logic [pobb_pkg::COORD_BITS-1:0] py[pobb_pkg::MAX_POINTS];
		int unsigned count;
		longint unsigned sx, sy, sxx, syy, sxy;
		box_t pending[$];
		int errors;
		longint arc_step[22] = '{1048576, 619011, 327068, 166025, 83335, 41708, 20859,
			10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

		function void clear_sums();
			count = 0;
			sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
		endfunction

		function longint to_zero_q38(longint v);
			return (v >= 0) ? (v >>> 38) : -((-v) >>> 38);
		endfunction

		function longint center_of(longint unsigned sum, longint unsigned n);
			longint unsigned q;
			q = (sum * 256 + n / 2) / n;
			return (q > 1048575) ? 1048575 : longint'(q);
		endfunction

		function box_t fit_box();
			longint unsigned n, cxx, cyy, cxy, ay, bx;
			bit aneg, bneg;
			longint z, ang, c, s, x, y, nx, ny, cx, cy, dx, dy, rx, ry;
			longint lo_x, hi_x, lo_y, hi_y, w, h;
			box_t b;
			n = (count != 0) ? count : 1;
			cxx = n * sxx - sx * sx;
			cyy = n * syy - sy * sy;
			cxy = n * sxy - sx * sy;
			aneg = cxy[63];
			ay = (aneg ? -cxy : cxy) << 1;
			bneg = cxx < cyy;
			bx = bneg ? cyy - cxx : cxx - cyy;
			while ((ay | bx) >= (64'd1 << 30)) begin
				ay >>= 1;
				bx >>= 1;
			end
			z = 0;
			if (ay != 0) begin
				x = longint'(bx);
				y = longint'(ay);
				for (int i = 0; i < 22; i++) begin
					if (y >= 0) begin
						nx = x + (y >>> i); ny = y - (x >>> i); z += arc_step[i];
					end else begin
						nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_step[i];
					end
					x = nx; y = ny;
				end
				if (z < 0) z = 0;
				if (z > (longint'(1) << 21)) z = longint'(1) << 21;
			end
			if (bneg) z = (longint'(1) << 22) - z;
			if (aneg) z = -z;
			ang = (z + 128) >>> 8;
			if (ang <= -16384) ang += 32768;
			cx = center_of(sx, n);
			cy = center_of(sy, n);
			if (ang == 0) begin
				c = longint'(1) << 30; s = 0;
			end else if (ang == 16384) begin
				c = 0; s = longint'(1) << 30;
			end else begin
				x = 652032874; y = 0; z = ang * 128;
				for (int i = 0; i < 22; i++) begin
					if (z >= 0) begin
						nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_step[i];
					end else begin
						nx = x + (y >>> i); ny = y - (x >>> i); z += arc_step[i];
					end
					x = nx; y = ny;
				end
				c = x; s = y;
			end
			lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
			for (int i = 0; i < count; i++) begin
				dx = longint'(px[i]) * 256 - cx;
				dy = longint'(py[i]) * 256 - cy;
				rx = to_zero_q38(dx * c + dy * s + (cx <<< 30));
				ry = to_zero_q38(dy * c - dx * s + (cy <<< 30));
				if (i == 0) begin
					lo_x = rx; hi_x = rx; lo_y = ry; hi_y = ry;
				end else begin
					if (rx < lo_x) lo_x = rx;
					if (rx > hi_x) hi_x = rx;
					if (ry < lo_y) lo_y = ry;
					if (ry > hi_y) hi_y = ry;
				end
			end
			w = hi_x - lo_x + 1;
			h = hi_y - lo_y + 1;
			if (w > 16383) w = 16383;
			if (h > 16383) h = 16383;
			b.cx = cx[19:0];
			b.cy = cy[19:0];
			b.angle = ang[15:0];
			b.short_len = (w < h) ? w[13:0] : h[13:0];
			b.long_len = (w < h) ? h[13:0] : w[13:0];
			return b;
		endfunction

		function void note_point(logic [11:0] x, logic [11:0] y, logic last);
			longint unsigned ux, uy;
			if (count < pobb_pkg::MAX_POINTS) begin
				px[count] = x;
				py[count] = y;
				count++;
				ux = x; uy = y;
				sx += ux; sy += uy;
				sxx += ux * ux; syy += uy * uy; sxy += ux * uy;
			end
			if (last) begin
				pending.push_back(fit_box());
				clear_sums();
			end
		endfunction

		function void check_box(box_t got);
			box_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected box cx %0d cy %0d angle %0d sides %0d %0d", $time,
					got.cx, got.cy, got.angle, got.short_len, got.long_len);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.cx !== e.cx) begin
				$display("%0t: center_x expected %0d actual %0d", $time, e.cx, got.cx);
				errors++;
			end
			if (got.cy !== e.cy) begin
				$display("%0t: center_y expected %0d actual %0d", $time, e.cy, got.cy);
				errors++;
			end
			if (got.angle !== e.angle) begin
				$display("%0t: axis_angle expected %0d actual %0d", $time, e.angle, got.angle);
				errors++;
			end
			if (got.short_len !== e.short_len) begin
				$display("%0t: short_side expected %0d actual %0d", $time, e.short_len,
					got.short_len);
				errors++;
			end
			if (got.long_len !== e.long_len) begin
				$display("%0t: long_side expected %0d actual %0d", $time, e.long_len,
					got.long_len);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [11:0] point_x;
	logic [11:0] point_y;
	logic last_point;
	logic out_valid;
	logic out_stall;
	logic [19:0] center_x;
	logic [19:0] center_y;
	logic signed [15:0] axis_angle;
	logic [13:0] short_side;
	logic [13:0] long_side;

	box_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int items_sent;
	longint cycles = 0;

	pca_oriented_bounding_box u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_x(center_x),
		.center_y(center_y),
		.axis_angle(axis_angle),
		.short_side(short_side),
		.long_side(long_side)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("pca_oriented_bounding_box test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		box_t got;
		bit take;
		forever begin
			@(negedge clk);
			take = arst_n && out_valid && !out_stall;
			got.cx = center_x;
			got.cy = center_y;
			got.angle = axis_angle;
			got.short_len = short_side;
			got.long_len = long_side;
			@(posedge clk);
			if (take) sb.check_box(got);
		end
	end

	task automatic send_point(logic [11:0] x, logic [11:0] y, logic last);
		bit ok;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		sb.note_point(x, y, last);
		items_sent++;
	endtask

	function automatic logic [11:0] clip(int v);
		return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : v[11:0];
	endfunction

	// Points along a random line with jitter, or uniform over the whole plane.
	task automatic send_contour(int len);
		int bx, by, sxs, sys, jit;
		bit spread;
		spread = ($urandom_range(3) == 0);
		bx = $urandom_range(4095);
		by = $urandom_range(4095);
		sxs = int'($urandom_range(32)) - 16;
		sys = int'($urandom_range(32)) - 16;
		jit = $urandom_range(6);
		for (int k = 0; k < len; k++) begin
			if (spread)
				send_point(12'($urandom), 12'($urandom), k == len - 1);
			else
				send_point(clip(bx + k * sxs + int'($urandom_range(2 * jit)) - jit),
					clip(by + k * sys + int'($urandom_range(2 * jit)) - jit),
					k == len - 1);
		end
	endtask

	initial begin
		int len;
		sb = new();
		sb.clear_sums();
		sb.errors = 0;
		items_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		last_point <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(12'd0, 12'd0, 1'b1);
		send_point(12'd4095, 12'd4095, 1'b1);
		send_point(12'd5, 12'd0, 1'b0);
		send_point(12'd5, 12'd4095, 1'b1);
		send_point(12'd0, 12'd7, 1'b0);
		send_point(12'd4095, 12'd7, 1'b1);
		send_point(12'd0, 12'd0, 1'b0);
		send_point(12'd4095, 12'd4095, 1'b1);
		send_point(12'd0, 12'd4095, 1'b0);
		send_point(12'd4095, 12'd0, 1'b1);
		send_point(12'd0, 12'd0, 1'b0);
		send_point(12'd4095, 12'd0, 1'b0);
		send_point(12'd4095, 12'd4095, 1'b0);
		send_point(12'd0, 12'd4095, 1'b1);
		send_point(12'd100, 12'd200, 1'b0);
		send_point(12'd100, 12'd200, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			case (items_sent * 4 / ITEM_TARGET)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			if (items_sent > 300 && items_sent < 340)
				len = pobb_pkg::MAX_POINTS + 6;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(60, 2);
			else
				len = $urandom_range(12, 1);
			send_contour(len);
		end
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("pca_oriented_bounding_box test passed");
		else
			$display("pca_oriented_bounding_box test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/pobb_pkg.sv
sv/pobb_dp.sv
sv/pobb_ctrl.sv
sv/pca_oriented_bounding_box.sv
sim/pca_oriented_bounding_box_test.sv
